FILE: hdl/keyed_rating_table_round_robin_core_assert.svh
// ----------------------------------------------------------------------------
// Keyed rating table assertion macros
// Shorthand for concurrent assertions clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_RATING_TABLE_ROUND_ROBIN_CORE_ASSERT_SVH
`define KEYED_RATING_TABLE_ROUND_ROBIN_CORE_ASSERT_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define KRTRR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyed rating table: assertion failed");

// Non-overlapping implication: the consequent holds in the cycle after the antecedent.
`define KRTRR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyed rating table: assertion failed");

`endif

FILE: hdl/krtrr_pkg.sv
// ----------------------------------------------------------------------------
// Keyed rating table package
// Sizes, codes, reset values and the table row layout shared by the design.
// ----------------------------------------------------------------------------
package krtrr_pkg;

   // Table geometry.
   localparam int ENTRIES    = 128;
   localparam int MODES      = 3;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int MODE_IDX_W = (MODES > 1) ? $clog2(MODES) : 1;

   // Field widths.
   localparam int OP_W       = 2;
   localparam int ID_W       = 32;
   localparam int KEY_W      = 31;
   localparam int MODE_W     = 2;
   localparam int RATING_W   = 24;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   // Register reset values.
   localparam logic [RATING_W-1:0] MIN_RATING_RST     = 24'd0;
   localparam logic [RATING_W-1:0] MAX_RATING_RST     = 24'hFF_FFFF;
   localparam logic [RATING_W-1:0] DEFAULT_RATING_RST = 24'd500000;
   localparam logic [KEY_W-1:0]    ID_LIMIT_RST       = 31'd1000000000;

   typedef logic [RATING_W-1:0] rating_type;

   typedef enum logic [OP_W-1:0] {
      OP_SET_BOTH,
      OP_SET_WORK,
      OP_GET_WORK,
      OP_GET_STORED
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE,
      STATUS_BAD_ID,
      STATUS_BAD_MODE
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RATING,
      CSR_MAX_RATING,
      CSR_DEFAULT_RATING,
      CSR_ID_LIMIT
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_RESULT
   } state_type;

   // One table row: key, per-mode flags and both rating copies.
   typedef struct packed {
      logic [KEY_W-1:0]                 key;
      logic [MODES-1:0]                 wflags;
      logic [MODES-1:0]                 sflags;
      logic [MODES-1:0][RATING_W-1:0]   wrating;
      logic [MODES-1:0][RATING_W-1:0]   srating;
   } row_type;

   localparam int ROW_W = $bits(row_type);

endpackage

FILE: hdl/krtrr_if.sv
// ----------------------------------------------------------------------------
// Keyed rating table channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface krtrr_req_if;
   import krtrr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic signed [ID_W-1:0]     profile_id;
   logic [MODE_W-1:0]          mode;
   logic [RATING_W-1:0]        rating_in;

   modport source (output valid, output operation, output profile_id, output mode,
                   output rating_in, input ready);
   modport sink (input valid, input operation, input profile_id, input mode,
                 input rating_in, output ready);
endinterface

interface krtrr_rsp_if;
   import krtrr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [RATING_W-1:0]   rating_out;
   logic                  present;
   logic [STATUS_W-1:0]   status;

   modport source (output valid, output rating_out, output present, output status,
                   input ready);
   modport sink (input valid, input rating_out, input present, input status,
                 output ready);
endinterface

FILE: hdl/krtrr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krtrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/keyed_rating_table_round_robin_core.sv
// ----------------------------------------------------------------------------
// Keyed rating table with round-robin replacement
// Fully associative table of rating entries held in one row-wide memory.
//
// Usage:
//   Requests arrive on req_chan (operation, profile_id, mode, rating_in) and
//   each produces exactly one response on rsp_chan (rating_out, present,
//   status). Both channels use valid/ready; a transaction completes when both
//   are high at a rising clock edge. Registers are written through csr_wr_en,
//   csr_index and csr_wr_data while no request is in flight.
//   A request with a valid mode and usable identifier scans all ENTRIES rows
//   through the single memory read port, one row per cycle, then writes the
//   row back for sets. Requests with a bad mode or identifier skip the scan
//   and respond directly. One request is processed at a time: no new request
//   is accepted until the current one has passed its result to the output.
//   Reset clears the per-row valid flops at once, so the table is empty
//   immediately and no clearing pass runs; the replacement pointer returns to
//   row 0 and the registers return to their defaults.
//   The response is held in an output register until taken. A new request is
//   accepted while a response waits; if the receiver still stalls when the
//   next response is ready, that response waits internally.
// ----------------------------------------------------------------------------
`include "keyed_rating_table_round_robin_core_assert.svh"

module keyed_rating_table_round_robin_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [krtrr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [krtrr_pkg::CSR_DATA_W-1:0] csr_wr_data,
   krtrr_req_if.sink                        req_chan,
   krtrr_rsp_if.source                      rsp_chan
);
   import krtrr_pkg::*;

   // Clamp a rating into the configured range, low bound first.
   function automatic rating_type clamp_rating(input rating_type v, input rating_type lo,
                                               input rating_type hi);
      rating_type r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Configuration registers.
   rating_type       min_rating_ff, min_rating_in;
   rating_type       max_rating_ff, max_rating_in;
   rating_type       default_rating_ff, default_rating_in;
   logic [KEY_W-1:0] id_limit_ff, id_limit_in;

   // Request context.
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [MODE_IDX_W-1:0]  mode_ff, mode_in;
   rating_type             value_ff, value_in;
   status_type             status_ff, status_in;

   // Scan pipeline.
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_vbit_ff, rd_vbit_in;
   logic              match_ff, match_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   row_type           match_row_ff, match_row_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   // Table bookkeeping.
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   // Result staging and output register.
   rating_type  res_rating_ff, res_rating_in;
   logic        res_present_ff, res_present_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rating_type  rsp_rating_ff, rsp_rating_in;
   logic        rsp_present_ff, rsp_present_in;
   status_type  rsp_status_ff, rsp_status_in;

   // Memory port signals and helpers.
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   row_type           wr_row;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ROW_W-1:0]  ram_rd_data;
   row_type           rd_row;
   logic              row_hit;
   logic              row_free;
   logic [IDX_W-1:0]  tgt_idx;
   logic              sel_flag;
   rating_type        sel_rating;
   logic              usable;
   logic              mode_bad;

   assign rd_row = row_type'(ram_rd_data);

   krtrr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_row),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Register write decode.
   always_comb begin
      min_rating_in     = min_rating_ff;
      max_rating_in     = max_rating_ff;
      default_rating_in = default_rating_ff;
      id_limit_in       = id_limit_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_RATING:     min_rating_in     = csr_wr_data[RATING_W-1:0];
            CSR_MAX_RATING:     max_rating_in     = csr_wr_data[RATING_W-1:0];
            CSR_DEFAULT_RATING: default_rating_in = csr_wr_data[RATING_W-1:0];
            CSR_ID_LIMIT:       id_limit_in       = csr_wr_data[KEY_W-1:0];
            default: ;
         endcase
      end
   end

   // Request checks: mode range first, then a positive key below the limit.
   assign mode_bad = int'(req_chan.mode) >= MODES;
   assign usable   = !req_chan.profile_id[ID_W-1] && (req_chan.profile_id != '0) &&
                     (req_chan.profile_id[KEY_W-1:0] < id_limit_ff);

   // Sequencer: accept, scan, write back, respond.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      mode_in        = mode_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      cnt_in         = cnt_ff;
      rd_pend_in     = 1'b0;
      rd_idx_in      = rd_idx_ff;
      rd_vbit_in     = rd_vbit_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      match_row_in   = match_row_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      ptr_in         = ptr_ff;
      valid_in       = valid_ff;
      res_rating_in  = res_rating_ff;
      res_present_in = res_present_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_rating_in  = rsp_rating_ff;
      rsp_present_in = rsp_present_ff;
      rsp_status_in  = rsp_status_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = cnt_ff[IDX_W-1:0];
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      wr_row         = match_row_ff;
      row_hit        = 1'b0;
      row_free       = 1'b0;
      tgt_idx        = ptr_ff;
      sel_flag       = 1'b0;
      sel_rating     = match_row_ff.srating[mode_ff];

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = op_type'(req_chan.operation);
               key_in   = req_chan.profile_id[KEY_W-1:0];
               mode_in  = MODE_IDX_W'(req_chan.mode);
               value_in = clamp_rating(req_chan.rating_in, min_rating_ff, max_rating_ff);
               cnt_in   = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               if (mode_bad || !usable) begin
                  status_in      = mode_bad ? STATUS_BAD_MODE : STATUS_BAD_ID;
                  res_rating_in  = default_rating_ff;
                  res_present_in = 1'b0;
                  state_in       = ST_RESULT;
               end else begin
                  status_in = STATUS_DONE;
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Issue one row read per cycle.
            if (cnt_ff != CNT_W'(ENTRIES)) begin
               ram_rd_en  = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_ff[IDX_W-1:0];
               rd_vbit_in = valid_ff[cnt_ff[IDX_W-1:0]];
            end
            // Examine the row that arrived: first key match and first free row.
            if (rd_pend_ff) begin
               row_hit  = rd_vbit_ff && (rd_row.key == key_ff);
               row_free = !rd_vbit_ff || ((rd_row.wflags == '0) && (rd_row.sflags == '0));
               if (row_hit && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = rd_idx_ff;
                  match_row_in = rd_row;
               end
               if (row_free && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
            // Scan finished: form the response.
            if ((cnt_ff == CNT_W'(ENTRIES)) && !rd_pend_ff) begin
               if ((op_ff == OP_SET_BOTH) || (op_ff == OP_SET_WORK)) begin
                  res_rating_in  = value_ff;
                  res_present_in = match_ff && match_row_ff.wflags[mode_ff];
                  state_in       = ST_WRITE;
               end else begin
                  if (op_ff == OP_GET_WORK) begin
                     sel_flag   = match_row_ff.wflags[mode_ff];
                     sel_rating = match_row_ff.wrating[mode_ff];
                  end else begin
                     sel_flag   = match_row_ff.sflags[mode_ff];
                     sel_rating = match_row_ff.srating[mode_ff];
                  end
                  if (match_ff && sel_flag) begin
                     res_rating_in  = clamp_rating(sel_rating, min_rating_ff, max_rating_ff);
                     res_present_in = 1'b1;
                  end else begin
                     res_rating_in  = default_rating_ff;
                     res_present_in = 1'b0;
                  end
                  state_in = ST_RESULT;
               end
            end
         end

         ST_WRITE: begin
            // Pick the row: matched key, first free row, or the round-robin victim.
            if (match_ff) begin
               tgt_idx = match_idx_ff;
            end else if (free_ff) begin
               tgt_idx = free_idx_ff;
            end else begin
               tgt_idx = ptr_ff;
               ptr_in  = (ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
            end
            // A newly allocated row starts with its key and all flags clear.
            if (!match_ff) begin
               wr_row.key    = key_ff;
               wr_row.wflags = '0;
               wr_row.sflags = '0;
            end
            wr_row.wrating[mode_ff] = value_ff;
            wr_row.wflags[mode_ff]  = 1'b1;
            if (op_ff == OP_SET_BOTH) begin
               wr_row.srating[mode_ff] = value_ff;
               wr_row.sflags[mode_ff]  = 1'b1;
            end
            ram_wr_en         = 1'b1;
            ram_wr_addr       = tgt_idx;
            valid_in[tgt_idx] = 1'b1;
            state_in          = ST_RESULT;
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_rating_in  = res_rating_ff;
               rsp_present_in = res_present_ff;
               rsp_status_in  = status_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         min_rating_ff     <= MIN_RATING_RST;
         max_rating_ff     <= MAX_RATING_RST;
         default_rating_ff <= DEFAULT_RATING_RST;
         id_limit_ff       <= ID_LIMIT_RST;
         rd_pend_ff        <= 1'b0;
         match_ff          <= 1'b0;
         free_ff           <= 1'b0;
         ptr_ff            <= '0;
         valid_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         min_rating_ff     <= min_rating_in;
         max_rating_ff     <= max_rating_in;
         default_rating_ff <= default_rating_in;
         id_limit_ff       <= id_limit_in;
         rd_pend_ff        <= rd_pend_in;
         match_ff          <= match_in;
         free_ff           <= free_in;
         ptr_ff            <= ptr_in;
         valid_ff          <= valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      mode_ff        <= mode_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      rd_vbit_ff     <= rd_vbit_in;
      match_idx_ff   <= match_idx_in;
      match_row_ff   <= match_row_in;
      free_idx_ff    <= free_idx_in;
      res_rating_ff  <= res_rating_in;
      res_present_ff <= res_present_in;
      rsp_rating_ff  <= rsp_rating_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Channel outputs.
   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.rating_out = rsp_rating_ff;
   assign rsp_chan.present    = rsp_present_ff;
   assign rsp_chan.status     = rsp_status_ff;

   // A matched row must be one that has been written since reset.
   `KRTRR_ASSERT_IMP(a_match_row_valid, match_ff, valid_ff[match_idx_ff])
   // The replacement pointer only advances out of the write-back state.
   `KRTRR_ASSERT_IMP(a_ptr_moves_on_write, !$past(reset) && !$stable(ptr_ff),
                     $past(state_ff) == ST_WRITE)
   // Only a usable set request reaches write-back.
   `KRTRR_ASSERT_IMP(a_write_is_good_set, state_ff == ST_WRITE,
                     (status_ff == STATUS_DONE) &&
                     ((op_ff == OP_SET_BOTH) || (op_ff == OP_SET_WORK)))
   // A taken request always moves the sequencer out of idle.
   `KRTRR_ASSERT_NXT(a_accept_leaves_idle, req_chan.valid && req_chan.ready,
                     state_ff != ST_IDLE)

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Keyed rating table testbench
// Drives request transactions into the keyed rating table core and checks
// every response against a cycle-free software copy of the table. Directed
// cases cover field extremes, bad modes, unusable identifiers and clamping,
// then random phases with varied register settings exercise lookup hits,
// allocation of free rows and round-robin replacement. Both sides idle in
// random bursts, and one long receiver hold-off backs the core up.
// ----------------------------------------------------------------------------
module testbench;
   import krtrr_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = ENTRIES + 16;
   localparam int PAD_W       = CSR_DATA_W - RATING_W;
   localparam int POOL_MAX    = 200;

   // One expected response transaction.
   typedef struct packed {
      rating_type rating;
      logic       present;
      status_type status;
   } rating_reply_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   krtrr_req_if req_bus ();
   krtrr_rsp_if rsp_bus ();

   keyed_rating_table_round_robin_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   // Shadow copy of the registers and of the table.
   rating_type       min_bound;
   rating_type       max_bound;
   rating_type       default_value;
   logic [KEY_W-1:0] id_bound;
   logic [KEY_W-1:0] row_key     [ENTRIES];
   logic [MODES-1:0] row_wflags  [ENTRIES];
   logic [MODES-1:0] row_sflags  [ENTRIES];
   rating_type       row_wrating [ENTRIES][MODES];
   rating_type       row_srating [ENTRIES][MODES];
   int               victim_ptr;

   rating_reply_type expected_replies [$];
   int  error_count    = 0;
   int  cycle_count    = 0;
   bit  idling_enabled = 1'b1;
   int  hold_request   = 0;
   int  hold_left      = 0;
   int  stall_left     = 0;

   logic signed [ID_W-1:0] key_pool [POOL_MAX];
   int pool_used = 1;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   // Table state after reset.
   task automatic model_reset();
      int i;
      int m;
      min_bound     = MIN_RATING_RST;
      max_bound     = MAX_RATING_RST;
      default_value = DEFAULT_RATING_RST;
      id_bound      = ID_LIMIT_RST;
      for (i = 0; i < ENTRIES; i++) begin
         row_key[i]    = '0;
         row_wflags[i] = '0;
         row_sflags[i] = '0;
         for (m = 0; m < MODES; m++) begin
            row_wrating[i][m] = '0;
            row_srating[i][m] = '0;
         end
      end
      victim_ptr = 0;
   endtask

   function automatic rating_type clamp_rating(rating_type v);
      if (v < min_bound) return min_bound;
      if (v > max_bound) return max_bound;
      return v;
   endfunction

   // Applies one request to the shadow table and returns its response.
   function automatic rating_reply_type predict_reply(op_type op,
                                                      logic signed [ID_W-1:0] id,
                                                      logic [MODE_W-1:0] mode,
                                                      rating_type rin);
      rating_reply_type reply;
      logic [ID_W-1:0]  raw;
      logic [MODES-1:0] flags;
      rating_type       value;
      int               hit;
      int               slot;
      int               i;
      int               m;
      raw           = id;
      reply.rating  = default_value;
      reply.present = 1'b0;
      reply.status  = STATUS_DONE;
      hit           = -1;
      slot          = -1;
      if (mode >= MODES) begin
         reply.status = STATUS_BAD_MODE;
      end else if (raw[ID_W-1] || raw == '0 || raw[KEY_W-1:0] >= id_bound) begin
         reply.status = STATUS_BAD_ID;
      end else begin
         // A key matches its row whatever the row's flags are.
         for (i = 0; i < ENTRIES; i++)
            if (hit < 0 && row_key[i] == raw[KEY_W-1:0]) hit = i;
         if (op == OP_SET_BOTH || op == OP_SET_WORK) begin
            value = clamp_rating(rin);
            if (hit >= 0) begin
               reply.present = row_wflags[hit][mode];
            end else begin
               // Lowest free row first, else the round-robin victim.
               for (i = 0; i < ENTRIES; i++)
                  if (slot < 0 && row_wflags[i] == '0 && row_sflags[i] == '0) slot = i;
               if (slot < 0) begin
                  slot       = victim_ptr;
                  victim_ptr = (slot + 1) % ENTRIES;
               end
               row_key[slot] = raw[KEY_W-1:0];
               for (m = 0; m < MODES; m++) begin
                  row_wrating[slot][m] = default_value;
                  row_srating[slot][m] = default_value;
               end
               row_wflags[slot] = '0;
               row_sflags[slot] = '0;
               hit = slot;
            end
            row_wrating[hit][mode] = value;
            row_wflags[hit][mode]  = 1'b1;
            if (op == OP_SET_BOTH) begin
               row_srating[hit][mode] = value;
               row_sflags[hit][mode]  = 1'b1;
            end
            reply.rating = value;
         end else if (hit >= 0) begin
            flags = (op == OP_GET_WORK) ? row_wflags[hit] : row_sflags[hit];
            if (flags[mode]) begin
               reply.rating  = clamp_rating((op == OP_GET_WORK) ? row_wrating[hit][mode]
                                                                : row_srating[hit][mode]);
               reply.present = 1'b1;
            end
         end
      end
      return reply;
   endfunction

   // Offers one request transaction and records its expected response.
   task automatic send_request(op_type op, logic signed [ID_W-1:0] id,
                               logic [MODE_W-1:0] mode, rating_type rin);
      if (idling_enabled && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.profile_id <= id;
      req_bus.mode       <= mode;
      req_bus.rating_in  <= rin;
      do @(posedge clock); while (!req_bus.ready);
      expected_replies.push_back(predict_reply(op, id, mode, rin));
   endtask

   // Register write; a trailing wait with the enable low keeps back-to-back writes apart.
   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MIN_RATING:     min_bound     = data[RATING_W-1:0];
         CSR_MAX_RATING:     max_bound     = data[RATING_W-1:0];
         CSR_DEFAULT_RATING: default_value = data[RATING_W-1:0];
         CSR_ID_LIMIT:       id_bound      = data[KEY_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Stops offering requests and waits until every response has arrived.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic fill_pool(int count);
      int i;
      pool_used = count;
      for (i = 0; i < count; i++)
         key_pool[i] = (id_bound > 1) ? ID_W'($urandom_range(1, id_bound - 1)) : 1;
   endtask

   function automatic rating_type pick_rating();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return min_bound + RATING_W'($urandom_range(0, 2)) - 1'b1;
         3:       return max_bound + RATING_W'($urandom_range(0, 2)) - 1'b1;
         default: return RATING_W'($urandom);
      endcase
   endfunction

   // Mostly pooled keys; the rest is noise, zero, minus one and identifiers at the limit.
   function automatic logic signed [ID_W-1:0] pick_id();
      logic [ID_W-1:0] limit;
      limit = {1'b0, id_bound};
      case ($urandom_range(0, 15))
         0:       return ID_W'($urandom);
         1:       return limit - 1'b1;
         2:       return limit;
         3:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
         default: return key_pool[$urandom_range(0, pool_used - 1)];
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      if ($urandom_range(0, 7) == 0) return MODE_W'(MODES + $urandom_range(0, 3 - MODES));
      return MODE_W'($urandom_range(0, MODES - 1));
   endfunction

   task automatic send_random_item();
      send_request(op_type'($urandom_range(0, 3)), pick_id(), pick_mode(), pick_rating());
   endtask

   // Response side: random stall bursts plus the requested long hold-off.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (idling_enabled && $urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 14);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compares each response transaction with the oldest expectation.
   always @(posedge clock) begin : check_replies
      rating_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected response", rsp_bus.rating_out, 0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_bus.rating_out !== want.rating)
               report_mismatch("rating_out", rsp_bus.rating_out, want.rating);
            if (rsp_bus.present !== want.present)
               report_mismatch("present", rsp_bus.present, want.present);
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
         end
      end
   end

   // Field extremes, every operation, bad modes and unusable identifiers.
   task automatic test_directed();
      send_request(OP_GET_WORK,   1, 0, 24'd0);
      send_request(OP_SET_BOTH,   1, 0, 24'd0);
      send_request(OP_GET_WORK,   1, 0, 24'd0);
      send_request(OP_GET_STORED, 1, 0, 24'd0);
      send_request(OP_SET_WORK,   2, 2, 24'hFF_FFFF);
      send_request(OP_GET_STORED, 2, 2, 24'd0);
      send_request(OP_GET_WORK,   2, 2, 24'd0);
      send_request(OP_SET_WORK,   1, 0, 24'd123456);
      send_request(OP_GET_STORED, 1, 0, 24'd0);
      send_request(OP_GET_WORK,   1, 0, 24'd0);
      send_request(OP_SET_BOTH,   1, 1, 24'd777);
      send_request(OP_GET_STORED, 1, 2, 24'd0);
      // Mode is checked ahead of the identifier.
      send_request(OP_SET_BOTH,   1, 3, 24'hFF_FFFF);
      send_request(OP_GET_WORK,   0, 3, 24'd0);
      send_request(OP_SET_BOTH,   0, 0, 24'd5);
      send_request(OP_SET_BOTH,   -1, 1, 24'd5);
      send_request(OP_GET_WORK,   32'sh8000_0000, 0, 24'd0);
      send_request(OP_SET_BOTH,   999_999_999, 0, 24'd42);
      send_request(OP_SET_BOTH,   1_000_000_000, 0, 24'd42);
      send_request(OP_GET_WORK,   32'sh7FFF_FFFF, 2, 24'd0);
      send_request(OP_GET_STORED, 999_999_999, 0, 24'd0);
      send_request(OP_GET_WORK,   3, 1, 24'd0);
      wait_until_idle();
   endtask

   // Clamp bounds, including min above max and an unclamped default.
   task automatic test_clamping();
      write_register(CSR_MIN_RATING, 1000);
      write_register(CSR_MAX_RATING, 900_000);
      write_register(CSR_DEFAULT_RATING, CSR_DATA_W'(24'hFF_FFFF));
      send_request(OP_SET_BOTH,   10, 0, 24'd5);
      send_request(OP_SET_WORK,   10, 1, 24'hFF_FFFF);
      send_request(OP_GET_WORK,   11, 0, 24'd0);
      send_request(OP_GET_STORED, 1, 0, 24'd0);
      send_request(OP_GET_WORK,   2, 2, 24'd0);
      wait_until_idle();
      write_register(CSR_MIN_RATING, 600_000);
      write_register(CSR_MAX_RATING, 400_000);
      write_register(CSR_DEFAULT_RATING, 0);
      send_request(OP_SET_BOTH,   12, 0, 24'd500_000);
      send_request(OP_SET_BOTH,   12, 1, 24'd700_000);
      send_request(OP_GET_WORK,   10, 0, 24'd0);
      send_request(OP_GET_STORED, 13, 2, 24'd0);
      wait_until_idle();
      write_register(CSR_MIN_RATING, CSR_DATA_W'(24'hFF_FFFF));
      write_register(CSR_MAX_RATING, 0);
      send_request(OP_SET_WORK,   12, 2, 24'd0);
      send_request(OP_GET_STORED, 12, 1, 24'd0);
      wait_until_idle();
      write_register(CSR_MIN_RATING, 0);
      send_request(OP_SET_BOTH,   13, 0, 24'hFF_FFFF);
      send_request(OP_GET_WORK,   12, 0, 24'd0);
      wait_until_idle();
      write_register(CSR_MAX_RATING, CSR_DATA_W'(MAX_RATING_RST));
      write_register(CSR_DEFAULT_RATING, CSR_DATA_W'(DEFAULT_RATING_RST));
   endtask

   // Identifier limit at its extremes and at a small value.
   task automatic test_id_limits();
      write_register(CSR_ID_LIMIT, 1);
      send_request(OP_SET_BOTH, 1, 0, 24'd9);
      send_request(OP_GET_WORK, 1, 0, 24'd0);
      send_request(OP_SET_WORK, 0, 1, 24'd9);
      wait_until_idle();
      write_register(CSR_ID_LIMIT, 31'h7FFF_FFFF);
      send_request(OP_SET_BOTH,   32'sh7FFF_FFFE, 1, 24'd31337);
      send_request(OP_GET_STORED, 32'sh7FFF_FFFE, 1, 24'd0);
      send_request(OP_GET_WORK,   32'sh7FFF_FFFF, 1, 24'd0);
      wait_until_idle();
      write_register(CSR_ID_LIMIT, 200);
      send_request(OP_SET_BOTH, 199, 2, 24'd1);
      send_request(OP_SET_BOTH, 200, 2, 24'd1);
      send_request(OP_GET_WORK, 199, 2, 24'd0);
      wait_until_idle();
      write_register(CSR_ID_LIMIT, ID_LIMIT_RST);
   endtask

   // Fills every row, then forces the victim pointer past a full wrap.
   task automatic test_replacement();
      int i;
      for (i = 0; i < ENTRIES; i++)
         send_request(op_type'($urandom_range(0, 1)), 1000 + i,
                      MODE_W'($urandom_range(0, MODES - 1)), pick_rating());
      for (i = 0; i < ENTRIES + 12; i++)
         send_request(op_type'($urandom_range(0, 1)), 5000 + i,
                      MODE_W'($urandom_range(0, MODES - 1)), pick_rating());
      for (i = 0; i < 40; i++)
         send_request(op_type'($urandom_range(0, 3)),
                      ($urandom_range(0, 1) == 0) ? 1000 + $urandom_range(0, ENTRIES - 1)
                                                  : 5000 + $urandom_range(0, ENTRIES + 11),
                      MODE_W'($urandom_range(0, MODES - 1)), pick_rating());
      wait_until_idle();
   endtask

   // Random phases, each with its own register setting and key pool.
   task automatic test_random_phases();
      int               phase;
      int               n;
      rating_type       lo;
      rating_type       hi;
      logic [KEY_W-1:0] limit;
      for (phase = 0; phase < 6; phase++) begin
         wait_until_idle();
         lo = RATING_W'($urandom_range(0, 3_000_000));
         hi = RATING_W'($urandom_range(8_000_000, 24'hFF_FFFF));
         if ($urandom_range(0, 3) == 0) begin
            write_register(CSR_MIN_RATING, {PAD_W'($urandom), hi});
            write_register(CSR_MAX_RATING, {PAD_W'($urandom), lo});
         end else begin
            write_register(CSR_MIN_RATING, {PAD_W'($urandom), lo});
            write_register(CSR_MAX_RATING, {PAD_W'($urandom), hi});
         end
         write_register(CSR_DEFAULT_RATING, {PAD_W'($urandom), RATING_W'($urandom)});
         case ($urandom_range(0, 2))
            0:       limit = KEY_W'($urandom_range(1, 32'h7FFF_FFFF));
            1:       limit = KEY_W'($urandom_range(2, 400));
            default: limit = ID_LIMIT_RST;
         endcase
         write_register(CSR_ID_LIMIT, limit);
         case (phase)
            0:       fill_pool(6);
            1:       fill_pool(40);
            2:       fill_pool(160);
            3:       fill_pool(POOL_MAX);
            4:       fill_pool(24);
            default: fill_pool(100);
         endcase
         for (n = 0; n < 110; n++) send_random_item();
      end
      wait_until_idle();
   endtask

   // The receiver holds off long enough for the core to stall its input.
   task automatic test_backpressure();
      int n;
      fill_pool(8);
      hold_request = 2000;
      for (n = 0; n < 12; n++)
         send_request(op_type'($urandom_range(0, 3)), key_pool[$urandom_range(0, 7)],
                      MODE_W'($urandom_range(0, MODES - 1)), pick_rating());
      wait_until_idle();
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_steady_stream();
      int n;
      idling_enabled = 1'b0;
      fill_pool(30);
      for (n = 0; n < 150; n++) send_random_item();
      wait_until_idle();
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.operation  = '0;
      req_bus.profile_id = '0;
      req_bus.mode       = '0;
      req_bus.rating_in  = '0;
      rsp_bus.ready      = 1'b0;
      model_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_clamping();
      test_id_limits();
      test_replacement();
      test_random_phases();
      test_backpressure();
      test_steady_stream();

      // Let any stray response show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
